### rtl/memory_ownership_accounting_top_assert.svh
// assertion macros for the ownership accounting block checks
`ifndef MEMORY_OWNERSHIP_ACCOUNTING_TOP_ASSERT_SVH
`define MEMORY_OWNERSHIP_ACCOUNTING_TOP_ASSERT_SVH

// same-cycle implication, checked at every rising edge outside reset
`define MOA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ownership accounting check failed");

// next-cycle implication, checked at every rising edge outside reset
`define MOA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ownership accounting check failed");

`endif

### rtl/moa_pkg.sv
// shared constants, types and helper functions of the ownership accounting block
`timescale 1ns / 1ps
`default_nettype none

package moa_pkg;

  // sizing
  localparam int NUM_PROCS    = 16;
  localparam int NUM_NODES    = 64;
  localparam int NODE_ID_BITS = 48;
  localparam int COUNT_BITS   = 40;

  localparam int PROC_BITS  = $clog2(NUM_PROCS);
  localparam int IDX_BITS   = $clog2(NUM_NODES);
  localparam int SWEEP_BITS = $clog2(NUM_NODES + 1);
  localparam int SUM_BITS   = ((COUNT_BITS > 32) ? COUNT_BITS : 32) + 1;

  // port field widths
  localparam int CMD_W    = 3;
  localparam int PID_W    = 4;
  localparam int NID_W    = 48;
  localparam int BYTES_W  = 32;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 40;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // command codes
  localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FORK    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SKIPPED  = 2'd3;

  // which process the counter port addresses
  typedef enum logic [1:0] {
    PSEL_PID   = 2'd0,
    PSEL_CHILD = 2'd1,
    PSEL_OWNER = 2'd2
  } proc_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic                load;
    logic                match_en;
    logic                encode_en;
    logic                credit_en;
    logic                charge_en;
    logic                amt_size;
    logic                entry_write;
    logic                entry_free;
    logic                sweep_en;
    logic                zero_pid;
    logic                clear_all;
    logic                report_en;
    proc_sel_t           proc_sel;
    logic [STATUS_W-1:0] status;
  } moa_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic hit;
    logic full;
    logic owner_is_pid;
    logic sweep_done;
  } moa_stat_t;

  // process index from a pid field, reduced modulo the process count
  function automatic logic [PROC_BITS-1:0] proc_of(input logic [PID_W-1:0] p);
    logic [PID_W-1:0]           r;
    logic [PID_W+PROC_BITS-1:0] w;
    r = p;
    for (int i = 0; i < 8; i++) begin
      if (int'(r) >= NUM_PROCS) begin
        r = r - PID_W'(NUM_PROCS);
      end
    end
    w = {{PROC_BITS{1'b0}}, r};
    return w[PROC_BITS-1:0];
  endfunction

  // process index back to the pid port width
  function automatic logic [PID_W-1:0] pid_out(input logic [PROC_BITS-1:0] p);
    logic [PID_W+PROC_BITS-1:0] w;
    w = {{PID_W{1'b0}}, p};
    return w[PID_W-1:0];
  endfunction

  // stored node key from the node id port
  function automatic logic [NODE_ID_BITS-1:0] key_of(input logic [NID_W-1:0] n);
    logic [NODE_ID_BITS+NID_W-1:0] w;
    w = {{NODE_ID_BITS{1'b0}}, n};
    return w[NODE_ID_BITS-1:0];
  endfunction

  // counter value to the total port width
  function automatic logic [TOTAL_W-1:0] total_out(input logic [COUNT_BITS-1:0] c);
    logic [COUNT_BITS+TOTAL_W-1:0] w;
    w = {{TOTAL_W{1'b0}}, c};
    return w[TOTAL_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/memory_ownership_accounting_top.sv
// top level of the per-process memory ownership accounting block
//
//   channel   handshake            payload
//   -------   ------------------   ----------------------------------------------
//   item in   start & !busy        command, pid, fork_child, node_id, byte_count
//   result    done (one cycle)     status, affected_pid, current_total, peak_total
//
// one result beat per item, on done, in the cycle after the last busy cycle.
// write, delete and fork step through tag compare, encode, table memory read
// and the single counter update port; release sweeps the owner memory, one
// entry a cycle.
// synchronous reset empties the table and zeroes all counters at once.
// the receiver cannot stall; a new item may be started in the cycle of done.
`timescale 1ns / 1ps
`default_nettype none

module memory_ownership_accounting_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [moa_pkg::CMD_W-1:0]     command,
  input  wire logic [moa_pkg::PID_W-1:0]     pid,
  input  wire logic [moa_pkg::PID_W-1:0]     fork_child,
  input  wire logic [moa_pkg::NID_W-1:0]     node_id,
  input  wire logic [moa_pkg::BYTES_W-1:0]   byte_count,
  output logic                               done,
  output logic [moa_pkg::STATUS_W-1:0]       status,
  output logic [moa_pkg::PID_W-1:0]          affected_pid,
  output logic [moa_pkg::TOTAL_W-1:0]        current_total,
  output logic [moa_pkg::TOTAL_W-1:0]        peak_total
);

  moa_pkg::moa_cmd_t  cmd;
  moa_pkg::moa_stat_t stat;

  // sequencer
  moa_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .busy    (busy),
    .cmd     (cmd),
    .stat    (stat)
  );

  // table and counters
  moa_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .pid_in        (pid),
    .child_in      (fork_child),
    .node_in       (node_id),
    .bytes_in      (byte_count),
    .done          (done),
    .status        (status),
    .affected_pid  (affected_pid),
    .current_total (current_total),
    .peak_total    (peak_total)
  );

endmodule

`default_nettype wire

### rtl/moa_ctrl.sv
// sequencer of the ownership accounting block
`timescale 1ns / 1ps
`default_nettype none

module moa_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [moa_pkg::CMD_W-1:0] command,
  output logic                          busy,
  output moa_pkg::moa_cmd_t             cmd,
  input  moa_pkg::moa_stat_t            stat
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_MATCH  = 9'b000000010,
    S_ENCODE = 9'b000000100,
    S_READ   = 9'b000001000,
    S_EXEC   = 9'b000010000,
    S_CHARGE = 9'b000100000,
    S_SWEEP  = 9'b001000000,
    S_CLEAR  = 9'b010000000,
    S_REPORT = 9'b100000000
  } state_t;

  state_t                         state, state_next;
  logic [moa_pkg::CMD_W-1:0]      cmd_r, cmd_r_next;
  logic [moa_pkg::STATUS_W-1:0]   status_r, status_r_next;
  moa_pkg::proc_sel_t             who_r, who_r_next;

  assign busy = (state != S_IDLE);

  // state and item registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cmd_r    <= moa_pkg::CMD_QUERY;
      status_r <= moa_pkg::ST_OK;
      who_r    <= moa_pkg::PSEL_PID;
    end else begin
      state    <= state_next;
      cmd_r    <= cmd_r_next;
      status_r <= status_r_next;
      who_r    <= who_r_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_next    = state;
    cmd_r_next    = cmd_r;
    status_r_next = status_r;
    who_r_next    = who_r;
    cmd           = '0;
    cmd.proc_sel  = moa_pkg::PSEL_PID;
    cmd.status    = status_r;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load      = 1'b1;
          cmd_r_next    = command;
          status_r_next = moa_pkg::ST_OK;
          who_r_next    = (command == moa_pkg::CMD_FORK) ? moa_pkg::PSEL_CHILD
                                                         : moa_pkg::PSEL_PID;
          case (command)
            moa_pkg::CMD_WRITE,
            moa_pkg::CMD_DELETE,
            moa_pkg::CMD_FORK:    state_next = S_MATCH;
            moa_pkg::CMD_RELEASE: state_next = S_SWEEP;
            moa_pkg::CMD_CLEAR:   state_next = S_CLEAR;
            default:              state_next = S_REPORT;
          endcase
        end
      end
      S_MATCH: begin
        cmd.match_en = 1'b1;
        state_next   = S_ENCODE;
      end
      S_ENCODE: begin
        cmd.encode_en = 1'b1;
        state_next    = S_READ;
      end
      S_READ: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_REPORT;
        case (cmd_r)
          moa_pkg::CMD_WRITE: begin
            if (stat.hit) begin
              // old owner gives back the recorded size first
              cmd.credit_en = 1'b1;
              cmd.proc_sel  = moa_pkg::PSEL_OWNER;
              cmd.amt_size  = 1'b1;
              state_next    = S_CHARGE;
            end else if (stat.full) begin
              status_r_next = moa_pkg::ST_FULL;
            end else begin
              state_next = S_CHARGE;
            end
          end
          moa_pkg::CMD_DELETE: begin
            if (!stat.hit) begin
              status_r_next = moa_pkg::ST_NOTFOUND;
            end else begin
              cmd.credit_en  = 1'b1;
              cmd.proc_sel   = moa_pkg::PSEL_OWNER;
              cmd.amt_size   = 1'b1;
              cmd.entry_free = 1'b1;
              who_r_next     = moa_pkg::PSEL_OWNER;
            end
          end
          moa_pkg::CMD_FORK: begin
            if (!stat.hit) begin
              status_r_next = moa_pkg::ST_NOTFOUND;
            end else if (!stat.owner_is_pid) begin
              status_r_next = moa_pkg::ST_SKIPPED;
            end else begin
              state_next = S_CHARGE;
            end
          end
          default: begin
            state_next = S_REPORT;
          end
        endcase
      end
      S_CHARGE: begin
        cmd.charge_en = 1'b1;
        if (cmd_r == moa_pkg::CMD_FORK) begin
          cmd.proc_sel = moa_pkg::PSEL_CHILD;
          cmd.amt_size = 1'b1;
        end else begin
          cmd.entry_write = 1'b1;
        end
        state_next = S_REPORT;
      end
      S_SWEEP: begin
        cmd.sweep_en = 1'b1;
        if (stat.sweep_done) begin
          cmd.zero_pid = 1'b1;
          state_next   = S_REPORT;
        end
      end
      S_CLEAR: begin
        cmd.clear_all = 1'b1;
        state_next    = S_REPORT;
      end
      S_REPORT: begin
        cmd.report_en = 1'b1;
        cmd.proc_sel  = who_r;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/moa_datapath.sv
// ownership table, process counters and result registers
`timescale 1ns / 1ps
`default_nettype none

module moa_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  moa_pkg::moa_cmd_t                  cmd,
  output moa_pkg::moa_stat_t                 stat,
  input  wire logic [moa_pkg::PID_W-1:0]     pid_in,
  input  wire logic [moa_pkg::PID_W-1:0]     child_in,
  input  wire logic [moa_pkg::NID_W-1:0]     node_in,
  input  wire logic [moa_pkg::BYTES_W-1:0]   bytes_in,
  output logic                               done,
  output logic [moa_pkg::STATUS_W-1:0]       status,
  output logic [moa_pkg::PID_W-1:0]          affected_pid,
  output logic [moa_pkg::TOTAL_W-1:0]        current_total,
  output logic [moa_pkg::TOTAL_W-1:0]        peak_total
);

  localparam int N  = moa_pkg::NUM_NODES;
  localparam int P  = moa_pkg::NUM_PROCS;
  localparam int IB = moa_pkg::IDX_BITS;
  localparam int PB = moa_pkg::PROC_BITS;
  localparam int CB = moa_pkg::COUNT_BITS;
  localparam int SB = moa_pkg::SUM_BITS;

  // index of the lowest set bit
  function automatic logic [IB-1:0] first_idx(input logic [N-1:0] v);
    logic [N-1:0]  low;
    logic [IB-1:0] idx;
    low = v & (~v + 1'b1);
    idx = '0;
    for (int i = 0; i < N; i++) begin
      if (low[i]) begin
        idx = idx | IB'(i);
      end
    end
    return idx;
  endfunction

  logic [PB-1:0]                   pid_q, child_q;
  logic [moa_pkg::NODE_ID_BITS-1:0] key_q;
  logic [moa_pkg::BYTES_W-1:0]     bytes_q;

  logic [moa_pkg::NODE_ID_BITS-1:0] tag [N];
  logic [N-1:0]                    valid;
  logic [N-1:0]                    match_c, match_q, free_q;
  logic                            hit_q, full_q;
  logic [IB-1:0]                   key_idx;

  logic [moa_pkg::SWEEP_BITS-1:0]  sweep_cnt;
  logic [IB-1:0]                   sweep_prev;
  logic                            sweep_pend, sweep_clr, sweep_done;
  logic [IB-1:0]                   rd_addr;

  logic [PB-1:0]                   owner_mem [N];
  logic [moa_pkg::BYTES_W-1:0]     size_mem [N];
  logic [PB-1:0]                   owner_q;
  logic [moa_pkg::BYTES_W-1:0]     size_q;

  logic [CB-1:0]                   cur [P];
  logic [CB-1:0]                   peak [P];
  logic [PB-1:0]                   rd_proc;
  logic [CB-1:0]                   cur_rd, peak_rd, credited, charged;
  logic [moa_pkg::BYTES_W-1:0]     amt;
  logic [SB-1:0]                   cur_w, amt_w, sum;

  // item operands
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pid_q   <= moa_pkg::proc_of(pid_in);
      child_q <= moa_pkg::proc_of(child_in);
      key_q   <= moa_pkg::key_of(node_in);
      bytes_q <= bytes_in;
    end
  end

  // node tags, each compared in place
  always_ff @(posedge clk) begin
    if (cmd.entry_write) begin
      tag[key_idx] <= key_q;
    end
  end

  // entry valid bits
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      valid <= '0;
    end else if (cmd.entry_write) begin
      valid[key_idx] <= 1'b1;
    end else if (cmd.entry_free) begin
      valid[key_idx] <= 1'b0;
    end
  end

  // parallel tag compare
  always_comb begin
    for (int i = 0; i < N; i++) begin
      match_c[i] = valid[i] && (tag[i] == key_q);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.match_en) begin
      match_q <= match_c;
      free_q  <= ~valid;
    end
  end

  // hit or first free entry
  always_ff @(posedge clk) begin
    if (cmd.encode_en) begin
      hit_q   <= |match_q;
      full_q  <= ~|free_q;
      key_idx <= (|match_q) ? first_idx(match_q) : first_idx(free_q);
    end
  end

  // release sweep over the owner memory, read one entry ahead of the write
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      sweep_cnt  <= '0;
      sweep_pend <= 1'b0;
    end else if (cmd.sweep_en) begin
      if (!sweep_done) begin
        sweep_cnt <= sweep_cnt + 1'b1;
      end
      sweep_pend <= !sweep_done;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_en) begin
      sweep_prev <= sweep_cnt[IB-1:0];
    end
  end

  assign sweep_done = (sweep_cnt == moa_pkg::SWEEP_BITS'(N));
  assign sweep_clr  = cmd.sweep_en && sweep_pend && valid[sweep_prev] && (owner_q == pid_q);
  assign rd_addr    = cmd.sweep_en ? sweep_cnt[IB-1:0] : key_idx;

  // owner memory
  always_ff @(posedge clk) begin
    if (sweep_clr) begin
      owner_mem[sweep_prev] <= '0;
    end else if (cmd.entry_write) begin
      owner_mem[key_idx] <= pid_q;
    end
    owner_q <= owner_mem[rd_addr];
  end

  // size memory
  always_ff @(posedge clk) begin
    if (cmd.entry_write) begin
      size_mem[key_idx] <= bytes_q;
    end
    size_q <= size_mem[rd_addr];
  end

  // counter port address
  always_comb begin
    case (cmd.proc_sel)
      moa_pkg::PSEL_PID:   rd_proc = pid_q;
      moa_pkg::PSEL_CHILD: rd_proc = child_q;
      moa_pkg::PSEL_OWNER: rd_proc = owner_q;
      default:             rd_proc = pid_q;
    endcase
  end

  // credit floors at zero, charge saturates
  always_comb begin
    cur_rd  = cur[rd_proc];
    peak_rd = peak[rd_proc];
    amt     = cmd.amt_size ? size_q : bytes_q;
    cur_w   = SB'(cur_rd);
    amt_w   = SB'(amt);
    sum     = cur_w + amt_w;
    if (amt_w > cur_w) begin
      credited = '0;
    end else begin
      credited = cur_rd - CB'(amt_w);
    end
    if (sum > SB'(moa_pkg::CNT_MAX)) begin
      charged = moa_pkg::CNT_MAX;
    end else begin
      charged = sum[CB-1:0];
    end
  end

  // current and peak counters
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      for (int i = 0; i < P; i++) begin
        cur[i]  <= '0;
        peak[i] <= '0;
      end
    end else if (cmd.credit_en) begin
      cur[rd_proc] <= credited;
    end else if (cmd.charge_en) begin
      cur[rd_proc] <= charged;
      if (charged > peak_rd) begin
        peak[rd_proc] <= charged;
      end
    end else if (cmd.zero_pid) begin
      cur[pid_q] <= '0;
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.report_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report_en) begin
      status        <= cmd.status;
      affected_pid  <= moa_pkg::pid_out(rd_proc);
      current_total <= moa_pkg::total_out(cur_rd);
      peak_total    <= moa_pkg::total_out(peak_rd);
    end
  end

  assign stat.hit          = hit_q;
  assign stat.full         = full_q;
  assign stat.owner_is_pid = (owner_q == pid_q);
  assign stat.sweep_done   = sweep_done;

endmodule

`default_nettype wire

### rtl/moa_checker.sv
// port-level checks of the ownership accounting block and their binding
`timescale 1ns / 1ps
`default_nettype none

`include "memory_ownership_accounting_top_assert.svh"

module moa_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done
);

  // an accepted item keeps the block busy in the next cycle
  `MOA_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)

  // a result beat comes only once the block is free again
  `MOA_ASSERT_NOW(a_done_idle, clk, rst, done, !busy)

  // every item ends in a result beat, raised as busy falls
  `MOA_ASSERT_NOW(a_fall_done, clk, rst, $fell(busy), done)

  // results never come in back-to-back cycles
  `MOA_ASSERT_NEXT(a_done_single, clk, rst, done, !done)

endmodule

bind memory_ownership_accounting_top moa_checker u_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

`default_nettype wire
